### rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Default width of the segment delay counter
  localparam int DELAY_BITS_DEF = 19;

  // Configuration register indexes
  localparam logic REG_UNIT_TICKS  = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] UNIT_TICKS_RST  = 16'd1;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // Segment lengths in delay units
  localparam logic [2:0] UNITS_NONE  = 3'd0;
  localparam logic [2:0] UNITS_READ  = 3'd1;
  localparam logic [2:0] UNITS_BIT   = 3'd2;
  localparam logic [2:0] UNITS_EDGE  = 3'd4;

  typedef enum logic [2:0] {
    REQ_NONE     = 3'd0,
    REQ_START    = 3'd1,
    REQ_STOP     = 3'd2,
    REQ_WRITE    = 3'd3,
    REQ_READ     = 3'd4,
    REQ_WAIT_ACK = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ST_A   = 4'd1,
    PH_ST_B   = 4'd2,
    PH_SP_A   = 4'd3,
    PH_SP_B   = 4'd4,
    PH_WR_SET = 4'd5,
    PH_WR_HI  = 4'd6,
    PH_WR_LO  = 4'd7,
    PH_RD_LO  = 4'd8,
    PH_RD_HI  = 4'd9,
    PH_AK_LO  = 4'd10,
    PH_AK_HI  = 4'd11,
    PH_POLL   = 4'd12,
    PH_FIN    = 4'd13
  } phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_value;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } out_item_t;

endpackage

### rtl/i2cm_if.sv
// Tick channel into the sequencer
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       ack_after_read;
  logic       sda_level;

  modport source (output valid, req_type, tx_byte, ack_after_read, sda_level, input ready);
  modport sink   (input valid, req_type, tx_byte, ack_after_read, sda_level, output ready);
endinterface

// Line levels and status out of the sequencer
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_value;
  logic       sda_drive_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, scl_level, sda_value, sda_drive_enable, busy_res, done_res,
                  rx_byte, ack_error, input ready);
  modport sink   (input valid, scl_level, sda_value, sda_drive_enable, busy_res, done_res,
                  rx_byte, ack_error, output ready);
endinterface

// Register write channel
interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic        idx;
  logic [15:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

### rtl/i2cm_seq.sv
module i2cm_seq
  import i2cm_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_item_t    item,
  input  logic [15:0] unit_ticks,
  input  logic [7:0]  ack_timeout,
  output out_item_t   res
);

  localparam int LW = 19;
  localparam int CW = (DELAY_BITS > LW) ? DELAY_BITS : LW;
  localparam logic [CW-1:0] DMAX = CW'((64'(1) << DELAY_BITS) - 64'(1));

  phase_t                phase_r, phase_nxt;
  logic [3:0]            bit_count_r, bit_count_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic [7:0]            poll_r, poll_nxt;
  logic [7:0]            rd_res_r, rd_res_nxt;
  logic                  tmo_r, tmo_nxt;
  logic                  scl_r, scl_nxt;
  logic                  sda_r, sda_nxt;
  logic                  oe_r, oe_nxt;
  logic                  ack_r, ack_nxt;

  logic [15:0]           unit_len;
  logic [DELAY_BITS-1:0] rd_tap;
  logic [DELAY_BITS-1:0] len_bit, len_edge, len_read;

  // Segment length minus one, saturated to the counter
  function automatic logic [DELAY_BITS-1:0] seg_cnt(input logic [2:0] units,
                                                    input logic [15:0] ulen);
    logic [CW-1:0] len;
    len = CW'(units) * CW'(ulen);
    if (len != '0) len = len - CW'(1);
    if (len > DMAX) len = DMAX;
    return len[DELAY_BITS-1:0];
  endfunction

  assign unit_len = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
  assign rd_tap   = DELAY_BITS'((CW'(unit_len) - CW'(1)) & DMAX);
  assign len_bit  = seg_cnt(UNITS_BIT, unit_len);
  assign len_edge = seg_cnt(UNITS_EDGE, unit_len);
  assign len_read = seg_cnt(UNITS_READ, unit_len);

  // One tick: take a command when idle, show lines, then advance
  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    delay_nxt     = delay_r;
    poll_nxt      = poll_r;
    rd_res_nxt    = rd_res_r;
    tmo_nxt       = tmo_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    oe_nxt        = oe_r;
    ack_nxt       = ack_r;

    if (phase_r == PH_IDLE) begin
      case (req_t'(item.req_type))
        REQ_START: begin
          phase_nxt = PH_ST_A; delay_nxt = len_edge;
          scl_nxt = 1'b1; sda_nxt = 1'b1; oe_nxt = 1'b1;
        end
        REQ_STOP: begin
          phase_nxt = PH_SP_A; delay_nxt = len_edge;
          scl_nxt = 1'b0; sda_nxt = 1'b0; oe_nxt = 1'b1;
        end
        REQ_WRITE: begin
          shift_nxt = item.tx_byte; bit_count_nxt = 4'd0;
          phase_nxt = PH_WR_SET; delay_nxt = len_bit;
          scl_nxt = 1'b0; sda_nxt = item.tx_byte[7]; oe_nxt = 1'b1;
        end
        REQ_READ: begin
          shift_nxt = 8'd0; bit_count_nxt = 4'd0; ack_nxt = item.ack_after_read;
          phase_nxt = PH_RD_LO; delay_nxt = len_bit;
          scl_nxt = 1'b0; sda_nxt = 1'b1; oe_nxt = 1'b0;
        end
        REQ_WAIT_ACK: begin
          poll_nxt = 8'd0;
          phase_nxt = PH_POLL; delay_nxt = '0;
          scl_nxt = 1'b1; sda_nxt = 1'b1; oe_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    // Levels shown on this tick
    res.scl_level        = scl_nxt;
    res.sda_value        = sda_nxt;
    res.sda_drive_enable = oe_nxt;
    res.busy_res         = (phase_nxt != PH_IDLE);
    res.done_res         = (phase_nxt == PH_FIN);

    if (phase_nxt == PH_FIN) begin
      phase_nxt = PH_IDLE;
    end else if (phase_nxt == PH_POLL) begin
      if (!item.sda_level) begin
        tmo_nxt = 1'b0;
        phase_nxt = PH_FIN; delay_nxt = '0;
        scl_nxt = 1'b0; sda_nxt = 1'b1; oe_nxt = 1'b0;
      end else if (poll_nxt >= ack_timeout) begin
        tmo_nxt = 1'b1;
        phase_nxt = PH_SP_A; delay_nxt = len_edge;
        scl_nxt = 1'b0; sda_nxt = 1'b0; oe_nxt = 1'b1;
      end else begin
        poll_nxt = poll_nxt + 8'd1;
      end
    end else if (phase_nxt != PH_IDLE) begin
      // Sample SDA on the first high tick of a read bit
      if (phase_nxt == PH_RD_HI && delay_nxt == rd_tap)
        shift_nxt = {shift_nxt[6:0], item.sda_level};
      if (delay_nxt != '0) begin
        delay_nxt = delay_nxt - DELAY_BITS'(1);
      end else begin
        case (phase_nxt)
          PH_ST_A: begin
            phase_nxt = PH_ST_B; delay_nxt = len_edge;
            scl_nxt = 1'b1; sda_nxt = 1'b0; oe_nxt = 1'b1;
          end
          PH_ST_B: begin
            phase_nxt = PH_FIN;
            scl_nxt = 1'b0; sda_nxt = 1'b0; oe_nxt = 1'b1;
          end
          PH_SP_A: begin
            phase_nxt = PH_SP_B; delay_nxt = len_edge;
            scl_nxt = 1'b1; sda_nxt = 1'b1; oe_nxt = 1'b1;
          end
          PH_SP_B: phase_nxt = PH_FIN;
          PH_WR_SET: begin
            phase_nxt = PH_WR_HI; delay_nxt = len_bit;
            scl_nxt = 1'b1; oe_nxt = 1'b1;
          end
          PH_WR_HI: begin
            phase_nxt = PH_WR_LO; delay_nxt = len_bit;
            scl_nxt = 1'b0; oe_nxt = 1'b1;
          end
          PH_WR_LO: begin
            bit_count_nxt = bit_count_nxt + 4'd1;
            shift_nxt = {shift_nxt[6:0], 1'b0};
            if (bit_count_nxt[3]) begin
              phase_nxt = PH_FIN;
            end else begin
              phase_nxt = PH_WR_SET; delay_nxt = len_bit;
              scl_nxt = 1'b0; sda_nxt = shift_nxt[7]; oe_nxt = 1'b1;
            end
          end
          PH_RD_LO: begin
            phase_nxt = PH_RD_HI; delay_nxt = len_read;
            scl_nxt = 1'b1; sda_nxt = 1'b1; oe_nxt = 1'b0;
          end
          PH_RD_HI: begin
            bit_count_nxt = bit_count_nxt + 4'd1;
            delay_nxt = len_bit; scl_nxt = 1'b0;
            if (bit_count_nxt[3]) begin
              phase_nxt = PH_AK_LO; sda_nxt = ~ack_nxt; oe_nxt = 1'b1;
            end else begin
              phase_nxt = PH_RD_LO; sda_nxt = 1'b1; oe_nxt = 1'b0;
            end
          end
          PH_AK_LO: begin
            phase_nxt = PH_AK_HI; delay_nxt = len_bit;
            scl_nxt = 1'b1; oe_nxt = 1'b1;
          end
          PH_AK_HI: begin
            rd_res_nxt = shift_nxt;
            phase_nxt = PH_FIN;
            scl_nxt = 1'b0; oe_nxt = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    res.rx_byte   = rd_res_nxt;
    res.ack_error = tmo_nxt;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      delay_r     <= '0;
      poll_r      <= 8'd0;
      rd_res_r    <= 8'd0;
      tmo_r       <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      oe_r        <= 1'b1;
      ack_r       <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      delay_r     <= delay_nxt;
      poll_r      <= poll_nxt;
      rd_res_r    <= rd_res_nxt;
      tmo_r       <= tmo_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      oe_r        <= oe_nxt;
      ack_r       <= ack_nxt;
    end
  end

endmodule

### rtl/i2c_bit_level_master_core.sv
// I2C master line sequencer.
// in_ch carries one clock tick per transfer: an optional command (start, stop,
// write byte, read byte, wait for acknowledge) and the sampled SDA level.
// Commands arriving while a command is in progress are ignored.
// out_ch returns one transfer per input tick: SCL level, SDA value and drive
// enable, busy, done, the last read byte and the acknowledge timeout flag.
// cfg_ch writes unit_ticks (index 0) and ack_timeout (index 1); it is always
// ready; the user must write it only while the sequencer is idle (not enforced).
// A tick taken from in_ch lands in the input register, is processed and is
// captured in the result register, from which out_ch takes it. One tick per
// cycle is taken while out_ch does not stall; the input register and the
// result register each hold one tick.
// When out_ch stalls, the result register holds, the input register fills and
// in_ch drops ready; nothing is lost and the line state does not advance.
// Reset (synchronous, rst_n low) returns to idle with SCL and SDA high and
// driven, both channels empty and the configuration registers at their reset values.
module i2c_bit_level_master_core
  import i2cm_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  i2cm_in_if.sink      in_ch,
  i2cm_out_if.source   out_ch,
  i2cm_cfg_if.sink     cfg_ch
);

  logic        in_v_r;
  in_item_t    in_item_r;
  logic        out_v_r;
  out_item_t   out_item_r;
  logic [15:0] unit_ticks_r;
  logic [7:0]  ack_timeout_r;

  logic        adv;
  logic        step;
  out_item_t   seq_res;

  assign adv   = !out_v_r || out_ch.ready;
  assign step  = in_v_r && adv;
  assign in_ch.ready  = !in_v_r || step;
  assign cfg_ch.ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.req_type       <= in_ch.req_type;
      in_item_r.tx_byte        <= in_ch.tx_byte;
      in_item_r.ack_after_read <= in_ch.ack_after_read;
      in_item_r.sda_level      <= in_ch.sda_level;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r  <= UNIT_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        REG_UNIT_TICKS:  unit_ticks_r  <= cfg_ch.data;
        REG_ACK_TIMEOUT: ack_timeout_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  i2cm_seq #(
    .DELAY_BITS(DELAY_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .unit_ticks  (unit_ticks_r),
    .ack_timeout (ack_timeout_r),
    .res         (seq_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= seq_res;
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.scl_level        = out_item_r.scl_level;
  assign out_ch.sda_value        = out_item_r.sda_value;
  assign out_ch.sda_drive_enable = out_item_r.sda_drive_enable;
  assign out_ch.busy_res         = out_item_r.busy_res;
  assign out_ch.done_res         = out_item_r.done_res;
  assign out_ch.rx_byte          = out_item_r.rx_byte;
  assign out_ch.ack_error        = out_item_r.ack_error;

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Request codes outside the defined set; the sequencer treats them as none
  localparam logic [2:0] REQ_BAD_LO = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;
  localparam longint unsigned DLY_MAX = (64'd1 << DELAY_BITS_DEF) - 64'd1;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 90;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();
  i2cm_cfg_if cfg_ch ();

  i2c_bit_level_master_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Line sequencer shadow state
  logic [15:0]     unit_ticks_q;
  logic [7:0]      ack_tmo_q;
  phase_t          ln_phase;
  logic [3:0]      bit_cnt;
  logic [7:0]      shreg;
  longint unsigned dly;
  logic [7:0]      polls;
  logic [7:0]      rd_byte;
  logic            tmo_flag;
  logic            scl_q, sda_q, oe_q, ack_sel;

  // Stimulus and scoreboard
  in_item_t    tick_q[$];
  out_item_t   due_q[$];
  in_item_t    cur_tick;
  int unsigned queued_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned got_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned ph_ticks = 0;
  int unsigned taken[8];
  int unsigned timeouts = 0;
  int unsigned gen_unit = 1;
  int unsigned gen_tmo = 250;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;

  function automatic longint unsigned unit_len();
    return (unit_ticks_q == 16'd0) ? 64'd1 : longint'(unit_ticks_q);
  endfunction

  // Enter a timed segment with the given line levels
  function automatic void seg(phase_t ph, int unsigned units, logic scl, logic sda, logic oe);
    longint unsigned len;
    len = units * unit_len();
    ln_phase = ph;
    dly = (len == 0) ? 64'd0 : len - 64'd1;
    if (dly > DLY_MAX) dly = DLY_MAX;
    scl_q = scl;
    sda_q = sda;
    oe_q = oe;
  endfunction

  // Segment sequencing once the current one has run out
  function automatic void next_segment();
    case (ln_phase)
      PH_ST_A:   seg(PH_ST_B, UNITS_EDGE, 1'b1, 1'b0, 1'b1);
      PH_ST_B:   seg(PH_FIN, UNITS_NONE, 1'b0, 1'b0, 1'b1);
      PH_SP_A:   seg(PH_SP_B, UNITS_EDGE, 1'b1, 1'b1, 1'b1);
      PH_SP_B:   seg(PH_FIN, UNITS_NONE, scl_q, sda_q, oe_q);
      PH_WR_SET: seg(PH_WR_HI, UNITS_BIT, 1'b1, sda_q, 1'b1);
      PH_WR_HI:  seg(PH_WR_LO, UNITS_BIT, 1'b0, sda_q, 1'b1);
      PH_WR_LO: begin
        bit_cnt = bit_cnt + 4'd1;
        shreg = shreg << 1;
        if (bit_cnt >= 4'd8) seg(PH_FIN, UNITS_NONE, scl_q, sda_q, oe_q);
        else seg(PH_WR_SET, UNITS_BIT, 1'b0, shreg[7], 1'b1);
      end
      PH_RD_LO:  seg(PH_RD_HI, UNITS_READ, 1'b1, 1'b1, 1'b0);
      PH_RD_HI: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) seg(PH_AK_LO, UNITS_BIT, 1'b0, ~ack_sel, 1'b1);
        else seg(PH_RD_LO, UNITS_BIT, 1'b0, 1'b1, 1'b0);
      end
      PH_AK_LO:  seg(PH_AK_HI, UNITS_BIT, 1'b1, sda_q, 1'b1);
      PH_AK_HI: begin
        rd_byte = shreg;
        seg(PH_FIN, UNITS_NONE, 1'b0, sda_q, 1'b1);
      end
      default:   ln_phase = PH_IDLE;
    endcase
  endfunction

  // One tick of the sequencer: returns the line levels and status it shows
  function automatic out_item_t line_tick(in_item_t t);
    out_item_t r;
    if (ln_phase == PH_IDLE) begin
      case (t.req_type)
        REQ_START: seg(PH_ST_A, UNITS_EDGE, 1'b1, 1'b1, 1'b1);
        REQ_STOP:  seg(PH_SP_A, UNITS_EDGE, 1'b0, 1'b0, 1'b1);
        REQ_WRITE: begin
          shreg = t.tx_byte;
          bit_cnt = 4'd0;
          seg(PH_WR_SET, UNITS_BIT, 1'b0, shreg[7], 1'b1);
        end
        REQ_READ: begin
          shreg = 8'd0;
          bit_cnt = 4'd0;
          ack_sel = t.ack_after_read;
          seg(PH_RD_LO, UNITS_BIT, 1'b0, 1'b1, 1'b0);
        end
        REQ_WAIT_ACK: begin
          polls = 8'd0;
          seg(PH_POLL, UNITS_NONE, 1'b1, 1'b1, 1'b0);
        end
        default: ;
      endcase
      if (ln_phase != PH_IDLE) taken[t.req_type]++;
    end

    r.scl_level = scl_q;
    r.sda_value = sda_q;
    r.sda_drive_enable = oe_q;
    r.busy_res = (ln_phase != PH_IDLE);
    r.done_res = (ln_phase == PH_FIN);

    if (ln_phase == PH_FIN) begin
      ln_phase = PH_IDLE;
    end else if (ln_phase == PH_POLL) begin
      if (!t.sda_level) begin
        tmo_flag = 1'b0;
        seg(PH_FIN, UNITS_NONE, 1'b0, 1'b1, 1'b0);
      end else if (polls >= ack_tmo_q) begin
        tmo_flag = 1'b1;
        timeouts++;
        seg(PH_SP_A, UNITS_EDGE, 1'b0, 1'b0, 1'b1);
      end else begin
        polls = polls + 8'd1;
      end
    end else if (ln_phase != PH_IDLE) begin
      // read data is sampled on the first SCL high tick
      if (ln_phase == PH_RD_HI && dly == ((unit_len() - 64'd1) & DLY_MAX))
        shreg = {shreg[6:0], t.sda_level};
      if (dly == 0) next_segment();
      else dly--;
    end

    r.rx_byte = rd_byte;
    r.ack_error = tmo_flag;
    return r;
  endfunction

  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got)
      note_fail($sformatf("mismatch on result %0d: %s expected %0h, got %0h",
                          got_cnt, name, want, got));
  endfunction

  // ---------------- stimulus building ----------------

  function automatic void add_tick(logic [2:0] req, logic [7:0] b, logic ack, logic sda);
    in_item_t t;
    t.req_type = req;
    t.tx_byte = b;
    t.ack_after_read = ack;
    t.sda_level = sda;
    tick_q.push_back(t);
    queued_cnt++;
    ph_ticks++;
  endfunction

  function automatic int unsigned eff_unit();
    return (gen_unit == 0) ? 1 : gen_unit;
  endfunction

  // Ticks from command to finishing tick, inclusive
  function automatic int unsigned cmd_len(logic [2:0] req);
    case (req)
      REQ_WRITE: return 48 * eff_unit() + 1;
      REQ_READ:  return 28 * eff_unit() + 1;
      default:   return 8 * eff_unit() + 1;
    endcase
  endfunction

  // Mostly quiet, now and then a command that lands while busy
  function automatic logic [2:0] junk_req();
    if ($urandom_range(0, 99) < 90) return REQ_NONE;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic void busy_ticks(int unsigned n);
    repeat (n) add_tick(junk_req(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
  endfunction

  function automatic void run_cmd(logic [2:0] req, logic [7:0] b, logic ack);
    add_tick(req, b, ack, 1'($urandom_range(0, 1)));
    busy_ticks(cmd_len(req) - 1);
  endfunction

  // Acknowledge wait: SDA low on poll k, or high until the timeout stop
  function automatic void ack_wait(bit give_up, int unsigned k);
    if (give_up) begin
      for (int unsigned i = 0; i <= gen_tmo; i++)
        add_tick((i == 0) ? REQ_WAIT_ACK : junk_req(), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b1);
      busy_ticks(8 * eff_unit() + 1);
    end else begin
      for (int unsigned i = 1; i <= k; i++)
        add_tick((i == 1) ? REQ_WAIT_ACK : junk_req(), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), (i == k) ? 1'b0 : 1'b1);
      busy_ticks(1);
    end
  endfunction

  function automatic void rand_ack_wait();
    bit give_up;
    int unsigned kmax;
    give_up = (gen_tmo <= 16) && ($urandom_range(0, 99) < 20);
    kmax = (gen_tmo + 1 < 6) ? gen_tmo + 1 : 6;
    ack_wait(give_up, $urandom_range(1, kmax));
  endfunction

  // Idle ticks between commands, sometimes none at all
  function automatic void gap();
    int unsigned roll;
    repeat ($urandom_range(0, 3)) begin
      roll = $urandom_range(0, 99);
      add_tick((roll < 80) ? REQ_NONE : ((roll < 90) ? REQ_BAD_LO : REQ_BAD_HI),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end
  endfunction

  function automatic void noise(int unsigned n);
    repeat (n) add_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Start, address, acknowledge, one or two data bytes, stop
  function automatic void transaction();
    run_cmd(REQ_START, 8'd0, 1'b0);
    gap();
    run_cmd(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0);
    gap();
    rand_ack_wait();
    repeat ($urandom_range(1, 2)) begin
      gap();
      if ($urandom_range(0, 1)) begin
        run_cmd(REQ_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        gap();
        rand_ack_wait();
      end else begin
        run_cmd(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    gap();
    run_cmd(REQ_STOP, 8'd0, 1'b0);
    gap();
  endfunction

  function automatic void random_phase(int unsigned budget);
    ph_ticks = 0;
    while (ph_ticks < budget) transaction();
    noise(30);
  endfunction

  // Hold new ticks back until every result is in and the sequencer is idle
  task automatic settle();
    while (1) begin
      while (sent_cnt != queued_cnt || got_cnt != sent_cnt) @(posedge clk);
      if (ln_phase == PH_IDLE) break;
      repeat (16) add_tick(REQ_NONE, 8'd0, 1'b0, 1'b1);
    end
  endtask

  task automatic set_regs(logic [15:0] unit, logic [7:0] tmo);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= REG_UNIT_TICKS;
    cfg_ch.data <= unit;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.idx <= REG_ACK_TIMEOUT;
    cfg_ch.data <= {8'($urandom_range(0, 255)), tmo};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    gen_unit = unit;
    gen_tmo = tmo;
  endtask

  // ---------------- driver and prediction ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      unit_ticks_q = UNIT_TICKS_RST;
      ack_tmo_q = ACK_TIMEOUT_RST;
      ln_phase = PH_IDLE;
      bit_cnt = 4'd0;
      shreg = 8'd0;
      dly = 0;
      polls = 8'd0;
      rd_byte = 8'd0;
      tmo_flag = 1'b0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      oe_q = 1'b1;
      ack_sel = 1'b0;
    end else begin
      // register write transfer
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.idx == REG_UNIT_TICKS) unit_ticks_q = cfg_ch.data;
        else ack_tmo_q = cfg_ch.data[7:0];
      end
      // tick transfer
      if (in_ch.valid && in_ch.ready) begin
        due_q.push_back(line_tick(cur_tick));
        sent_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_q.size() != 0 &&
            ((sent_cnt >= 700 && sent_cnt < 900) || $urandom_range(0, 99) >= 36)) begin
          cur_tick = tick_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= cur_tick.req_type;
          in_ch.tx_byte <= cur_tick.tx_byte;
          in_ch.ack_after_read <= cur_tick.ack_after_read;
          in_ch.sda_level <= cur_tick.sda_level;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor and checking ----------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          note_fail($sformatf("result %0d arrived with nothing pending", got_cnt));
        end else begin
          want = due_q.pop_front();
          cmp_field("scl_level", want.scl_level, out_ch.scl_level);
          cmp_field("sda_value", want.sda_value, out_ch.sda_value);
          cmp_field("sda_drive_enable", want.sda_drive_enable, out_ch.sda_drive_enable);
          cmp_field("busy_res", want.busy_res, out_ch.busy_res);
          cmp_field("done_res", want.done_res, out_ch.done_res);
          cmp_field("rx_byte", want.rx_byte, out_ch.rx_byte);
          cmp_field("ack_error", want.ack_error, out_ch.ack_error);
        end
        got_cnt++;
      end
      // one long hold-off while the sender keeps going, so the input backs up
      if (!hold_used && got_cnt >= 400 && tick_q.size() > 20) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (got_cnt >= 700 && got_cnt < 900) || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // ---------------- watchdog ----------------
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------- test sequence ----------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_NONE;
    in_ch.tx_byte = 8'd0;
    in_ch.ack_after_read = 1'b0;
    in_ch.sda_level = 1'b1;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = REG_UNIT_TICKS;
    cfg_ch.data = 16'd0;
    foreach (taken[i]) taken[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed at reset settings: unknown codes, stop from idle with a start
    // landing while busy, extreme bytes, ack on first and later polls, ACK/NACK reads
    add_tick(REQ_BAD_LO, 8'hA5, 1'b1, 1'b1);
    add_tick(REQ_BAD_HI, 8'h5A, 1'b0, 1'b0);
    add_tick(REQ_STOP, 8'd0, 1'b0, 1'b1);
    add_tick(REQ_START, 8'h3C, 1'b1, 1'b1);
    busy_ticks(cmd_len(REQ_STOP) - 2);
    run_cmd(REQ_START, 8'd0, 1'b0);
    run_cmd(REQ_WRITE, 8'hFF, 1'b0);
    ack_wait(1'b0, 1);
    run_cmd(REQ_WRITE, 8'h00, 1'b1);
    ack_wait(1'b0, 3);
    run_cmd(REQ_READ, 8'h00, 1'b1);
    run_cmd(REQ_READ, 8'hFF, 1'b0);
    run_cmd(REQ_STOP, 8'd0, 1'b0);
    settle();

    // Zero unit length and zero timeout: first high poll gives up
    set_regs(16'd0, 8'd0);
    ack_wait(1'b1, 0);
    ack_wait(1'b0, 1);
    random_phase(150);
    settle();

    set_regs(16'd2, 8'd1);
    random_phase(200);
    settle();

    // Longest timeout, run out in full
    set_regs(16'd1, 8'd255);
    run_cmd(REQ_START, 8'd0, 1'b0);
    run_cmd(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0);
    ack_wait(1'b1, 0);
    random_phase(100);
    settle();

    set_regs(16'd3, 8'($urandom_range(2, 12)));
    random_phase(220);
    settle();

    // Widest unit: a start that stays busy for the rest of the run
    set_regs(16'hFFFF, 8'd7);
    add_tick(REQ_START, 8'd0, 1'b0, 1'b1);
    noise(120);

    while (sent_cnt != queued_cnt || got_cnt != sent_cnt) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_q.size() != 0)
      note_fail($sformatf("%0d results never arrived", due_q.size()));

    $display("Run: %0d ticks sent, %0d results checked, %0d failures.",
             sent_cnt, got_cnt, fail_cnt);
    $display("Commands taken: %0d start, %0d stop, %0d write, %0d read, %0d ack wait (%0d timed out).",
             taken[REQ_START], taken[REQ_STOP], taken[REQ_WRITE], taken[REQ_READ],
             taken[REQ_WAIT_ACK], timeouts);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
